### hw/rtl/baro_pkg.sv
// Package: shared widths, types and helpers for the barometric compensation block.
package baro_pkg;

  localparam int unsigned DivBits    = 64;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
  } tcoef_t;

  typedef enum logic [1:0] {
    REG_TEMP    = 2'd0,
    REG_PRESS_A = 2'd1,
    REG_PRESS_B = 2'd2,
    REG_PRESS_C = 2'd3
  } reg_idx_t;

  function automatic u64_t sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

endpackage

### hw/rtl/baro_div.sv
// Pipelined restoring divider: one quotient bit per stage, signed operands.
module baro_div
  import baro_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] in_num,
  input  logic [63:0] in_den,
  input  logic [71:0] in_tag,
  output logic        out_vld,
  output logic [63:0] out_quo,
  output logic [71:0] out_tag
);

  localparam int unsigned N = DivBits;

  logic [N:0]     vld_r;
  logic [63:0]    rem_r [N+1];
  logic [63:0]    quo_r [N+1];
  logic [63:0]    den_r [N+1];
  logic           neg_r [N+1];
  logic [71:0]    tag_r [N+1];
  logic [63:0]    num_mag;
  logic [63:0]    den_mag;

  always_comb begin
    num_mag = in_num[63] ? (64'd0 - in_num) : in_num;
    den_mag = in_den[63] ? (64'd0 - in_den) : in_den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= 64'd0;
    quo_r[0] <= num_mag;
    den_r[0] <= den_mag;
    neg_r[0] <= in_num[63] ^ in_den[63];
    tag_r[0] <= in_tag;
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [64:0] shifted;
    logic [64:0] diff;
    always_comb begin
      shifted = {rem_r[s], quo_r[s][63]};
      diff    = shifted - {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!diff[64]) begin
        rem_r[s+1] <= diff[63:0];
      end else begin
        rem_r[s+1] <= shifted[63:0];
      end
      quo_r[s+1] <= {quo_r[s][62:0], ~diff[64]};
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign out_vld = vld_r[N];
  assign out_quo = neg_r[N] ? (64'd0 - quo_r[N]) : quo_r[N];
  assign out_tag = tag_r[N];

endmodule

### hw/rtl/baro_sensor_compensation_top.sv
// Top level: barometric sensor compensation pipeline with APB configuration.
//
// A request (start high while busy is low) is taken every clock cycle; busy stays low.
// Each request gives one result, marked by out_valid. Between the edge that takes it and
// that result lie seven arithmetic stages, a 65-stage restoring divider (input register
// plus one stage per quotient bit) and five further stages. Results are shown for one
// cycle only and the receiver cannot stall them. Calibration registers are 48 bits at
// byte addresses 0, 8, 16, 24; write them only while no request is in flight.
module baro_sensor_compensation_top
  import baro_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_raw_temp,
  input  logic [19:0] in_raw_press,
  output logic        out_valid,
  output logic signed [16:0] out_temp_centi,
  output logic signed [31:0] out_fine_temp,
  output logic [31:0] out_press_q24_8,
  output logic        out_press_invalid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [47:0] cfg_tc_r, cfg_pa_r, cfg_pb_r, cfg_pc_r;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_tc_r <= '0;
      cfg_pa_r <= '0;
      cfg_pb_r <= '0;
      cfg_pc_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        REG_TEMP:    cfg_tc_r <= pwdata[47:0];
        REG_PRESS_A: cfg_pa_r <= pwdata[47:0];
        REG_PRESS_B: cfg_pb_r <= pwdata[47:0];
        REG_PRESS_C: cfg_pc_r <= pwdata[47:0];
        default:     cfg_tc_r <= cfg_tc_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TEMP:    prdata = {16'd0, cfg_tc_r};
      REG_PRESS_A: prdata = {16'd0, cfg_pa_r};
      REG_PRESS_B: prdata = {16'd0, cfg_pb_r};
      REG_PRESS_C: prdata = {16'd0, cfg_pc_r};
      default:     prdata = 64'd0;
    endcase
  end

  tcoef_t tc;
  assign tc = tcoef_t'({cfg_tc_r[15:0], cfg_tc_r[31:16], cfg_tc_r[47:32]});
  u64_t p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign p1 = {48'd0, cfg_pa_r[15:0]};
  assign p2 = sx16(cfg_pa_r[31:16]);
  assign p3 = sx16(cfg_pa_r[47:32]);
  assign p4 = sx16(cfg_pb_r[15:0]);
  assign p5 = sx16(cfg_pb_r[31:16]);
  assign p6 = sx16(cfg_pb_r[47:32]);
  assign p7 = sx16(cfg_pc_r[15:0]);
  assign p8 = sx16(cfg_pc_r[31:16]);
  assign p9 = sx16(cfg_pc_r[47:32]);

  logic acc;
  assign acc = start && !busy;

  // Stage 1: temperature differences and products
  logic        s1_v_r;
  logic [31:0] s1_m1_r, s1_sq_r;
  logic [19:0] s1_ap_r;
  logic [31:0] d1, d2;
  assign d1 = {15'd0, in_raw_temp[19:3]} - {15'd0, tc.t1, 1'b0};
  assign d2 = {16'd0, in_raw_temp[19:4]} - {16'd0, tc.t1};

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= acc;
  end
  always_ff @(posedge clk) begin
    s1_m1_r <= d1 * {{16{tc.t2[15]}}, tc.t2};
    s1_sq_r <= d2 * d2;
    s1_ap_r <= in_raw_press;
  end

  // Stage 2: T3 term
  logic        s2_v_r;
  logic [31:0] s2_tv1_r, s2_m3_r;
  logic [19:0] s2_ap_r;
  logic [31:0] sq_sh;
  assign sq_sh = 32'($signed(s1_sq_r) >>> 12);
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    s2_tv1_r <= 32'($signed(s1_m1_r) >>> 11);
    s2_m3_r  <= sq_sh * {{16{tc.t3[15]}}, tc.t3};
    s2_ap_r  <= s1_ap_r;
  end

  // Stage 3: fine temperature
  logic        s3_v_r;
  logic [31:0] s3_tf_r;
  logic [19:0] s3_ap_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else        s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    s3_tf_r <= s2_tv1_r + 32'($signed(s2_m3_r) >>> 14);
    s3_ap_r <= s2_ap_r;
  end

  // Stage 4: centi-degrees, v1 and its square
  logic        s4_v_r;
  logic [31:0] s4_tf_r;
  logic [16:0] s4_tc_r;
  logic [19:0] s4_ap_r;
  u64_t        s4_v1_r, s4_vsq_r;
  u64_t        tf64, tc64, v1a;
  logic signed [63:0] tcs;
  logic signed [33:0] v1n;
  assign tf64 = {{32{s3_tf_r[31]}}, s3_tf_r};
  assign tc64 = 64'($signed(tf64 * 64'd5 + 64'd128) >>> 8);
  assign tcs  = $signed(tc64);
  assign v1a  = tf64 - 64'd128000;
  // v1 always fits in 34 signed bits, so square it at that width
  assign v1n  = $signed(v1a[33:0]);
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else        s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    s4_tf_r <= s3_tf_r;
    if (tcs > 64'sd65535)       s4_tc_r <= 17'h0FFFF;
    else if (tcs < -64'sd65536) s4_tc_r <= 17'h10000;
    else                        s4_tc_r <= tc64[16:0];
    s4_ap_r  <= s3_ap_r;
    s4_v1_r  <= v1a;
    s4_vsq_r <= 64'(v1n * v1n);
  end

  // Stage 5: coefficient products
  logic        s5_v_r;
  logic [31:0] s5_tf_r;
  logic [16:0] s5_tc_r;
  logic [19:0] s5_ap_r;
  u64_t        s5_a_r, s5_b_r, s5_c_r, s5_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else        s5_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    s5_tf_r <= s4_tf_r;
    s5_tc_r <= s4_tc_r;
    s5_ap_r <= s4_ap_r;
    s5_a_r  <= s4_vsq_r * p6;
    s5_b_r  <= s4_v1_r * p5;
    s5_c_r  <= s4_vsq_r * p3;
    s5_d_r  <= s4_v1_r * p2;
  end

  // Stage 6: v2 and the divisor product
  logic        s6_v_r;
  logic [31:0] s6_tf_r;
  logic [16:0] s6_tc_r;
  logic [19:0] s6_ap_r;
  u64_t        s6_v2_r, s6_dp_r;
  u64_t        v1b;
  assign v1b = 64'($signed(s5_c_r) >>> 8) + (s5_d_r << 12);
  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else        s6_v_r <= s5_v_r;
  end
  always_ff @(posedge clk) begin
    s6_tf_r <= s5_tf_r;
    s6_tc_r <= s5_tc_r;
    s6_ap_r <= s5_ap_r;
    s6_v2_r <= s5_a_r + (s5_b_r << 17) + (p4 << 35);
    s6_dp_r <= ((64'd1 << 47) + v1b) * p1;
  end

  // Stage 7: numerator and divisor
  logic        s7_v_r;
  logic [31:0] s7_tf_r;
  logic [16:0] s7_tc_r;
  u64_t        s7_num_r, s7_den_r;
  u64_t        pa;
  assign pa = 64'd1048576 - {44'd0, s6_ap_r};
  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else        s7_v_r <= s6_v_r;
  end
  always_ff @(posedge clk) begin
    s7_tf_r  <= s6_tf_r;
    s7_tc_r  <= s6_tc_r;
    s7_num_r <= ((pa << 31) - s6_v2_r) * 64'd3125;
    s7_den_r <= 64'($signed(s6_dp_r) >>> 33);
  end

  logic        dv_v;
  u64_t        dv_q;
  logic [71:0] dv_tag;
  logic        dv_zero;
  logic [16:0] dv_tc;
  logic [31:0] dv_tf;

  baro_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s7_v_r),
    .in_num  (s7_num_r),
    .in_den  (s7_den_r),
    .in_tag  ({22'd0, s7_den_r == 64'd0, s7_tc_r, s7_tf_r}),
    .out_vld (dv_v),
    .out_quo (dv_q),
    .out_tag (dv_tag)
  );
  assign dv_tf   = dv_tag[31:0];
  assign dv_tc   = dv_tag[48:32];
  assign dv_zero = dv_tag[49];

  // Post stage A: q, P8*p
  logic        pa_v_r, pa_z_r;
  logic [16:0] pa_tc_r;
  logic [31:0] pa_tf_r;
  u64_t        pa_p_r, pa_q_r, pa_w2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pa_v_r <= 1'b0;
    else        pa_v_r <= dv_v;
  end
  always_ff @(posedge clk) begin
    pa_z_r  <= dv_zero;
    pa_tc_r <= dv_tc;
    pa_tf_r <= dv_tf;
    pa_p_r  <= dv_q;
    pa_q_r  <= 64'($signed(dv_q) >>> 13);
    pa_w2_r <= 64'($signed(p8 * dv_q) >>> 19);
  end

  // Post stage B: P9*q
  logic        pb_v_r, pb_z_r;
  logic [16:0] pb_tc_r;
  logic [31:0] pb_tf_r;
  u64_t        pb_p_r, pb_q_r, pb_w2_r, pb_m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pb_v_r <= 1'b0;
    else        pb_v_r <= pa_v_r;
  end
  always_ff @(posedge clk) begin
    pb_z_r  <= pa_z_r;
    pb_tc_r <= pa_tc_r;
    pb_tf_r <= pa_tf_r;
    pb_p_r  <= pa_p_r;
    pb_q_r  <= pa_q_r;
    pb_w2_r <= pa_w2_r;
    pb_m_r  <= p9 * pa_q_r;
  end

  // Post stage C: times q again, as 32-bit partial products of the low 64 bits
  logic        pc_v_r, pc_z_r;
  logic [16:0] pc_tc_r;
  logic [31:0] pc_tf_r;
  u64_t        pc_p_r, pc_w2_r, pc_ll_r;
  logic [31:0] pc_x_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pc_v_r <= 1'b0;
    else        pc_v_r <= pb_v_r;
  end
  always_ff @(posedge clk) begin
    pc_z_r  <= pb_z_r;
    pc_tc_r <= pb_tc_r;
    pc_tf_r <= pb_tf_r;
    pc_p_r  <= pb_p_r;
    pc_w2_r <= pb_w2_r;
    pc_ll_r <= {32'd0, pb_m_r[31:0]} * {32'd0, pb_q_r[31:0]};
    pc_x_r  <= pb_m_r[31:0] * pb_q_r[63:32] + pb_m_r[63:32] * pb_q_r[31:0];
  end

  // Post stage D: recombine the partial products and scale
  logic        pd_v_r, pd_z_r;
  logic [16:0] pd_tc_r;
  logic [31:0] pd_tf_r;
  u64_t        pd_p_r, pd_w2_r, pd_w1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pd_v_r <= 1'b0;
    else        pd_v_r <= pc_v_r;
  end
  always_ff @(posedge clk) begin
    pd_z_r  <= pc_z_r;
    pd_tc_r <= pc_tc_r;
    pd_tf_r <= pc_tf_r;
    pd_p_r  <= pc_p_r;
    pd_w2_r <= pc_w2_r;
    pd_w1_r <= 64'($signed(pc_ll_r + {pc_x_r, 32'd0}) >>> 25);
  end

  // Output register
  logic        o_v_r, o_z_r;
  logic [16:0] o_tc_r;
  logic [31:0] o_tf_r, o_p_r;
  u64_t        pfin;
  assign pfin = 64'($signed(pd_p_r + pd_w1_r + pd_w2_r) >>> 8) + (p7 << 4);
  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else        o_v_r <= pd_v_r;
  end
  always_ff @(posedge clk) begin
    o_z_r  <= pd_z_r;
    o_tc_r <= pd_tc_r;
    o_tf_r <= pd_tf_r;
    o_p_r  <= pd_z_r ? 32'd0 : pfin[31:0];
  end

  assign out_valid         = o_v_r;
  assign out_temp_centi    = $signed(o_tc_r);
  assign out_fine_temp     = $signed(o_tf_r);
  assign out_press_q24_8   = o_p_r;
  assign out_press_invalid = o_z_r;

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_invalid |-> out_press_q24_8 == 32'd0)
    else $error("invalid result with nonzero pressure");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    s7_v_r |-> ##(DivBits + 6) out_valid)
    else $error("result lost in pipeline");
  a_fine: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |=> s5_tf_r == $past(s4_tf_r))
    else $error("fine temperature corrupted");

endmodule
